/* src/lrd_pkg.sv */
package lrd_pkg;

  // CRC-32, reflected form
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Result transaction, first field in the highest bits
  typedef struct packed {
    logic [31:0] computed_check;
    logic [31:0] stored_check;
    logic [31:0] metadata_length;
    logic [31:0] vector_length;
    logic [31:0] document_id;
    logic [7:0]  operation_code;
    logic [63:0] sequence_number;
    logic [33:0] payload_index;
    logic [7:0]  payload_byte;
    logic [2:0]  event_kind;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

  // Advance the CRC by one byte, one bit per step
  function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

/* src/lrd_out_buf.sv */
module lrd_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lrd_pkg::result_t push_data,
  output logic             ready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output lrd_pkg::result_t m_data
);

  logic             main_valid;
  logic             skid_valid;
  lrd_pkg::result_t main_data;
  lrd_pkg::result_t skid_data;

  assign ready    = !skid_valid;
  assign m_tvalid = main_valid;
  assign m_data   = main_data;

  // Refill the output register from the skid stage first, else from the parser
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || m_tready) begin
      if (skid_valid) begin
        main_data  <= skid_data;
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_data  <= push_data;
        main_valid <= push;
      end
    end else if (push) begin
      skid_data  <= push_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

/* src/log_record_deframer_crc32.sv */
// Each result is registered in the output stage before it appears on m_tvalid.
// Throughput: one byte per cycle while s_tready is high; CRC update, field counter and compare sit in one stage.
// A two-entry output stage keeps s_tready high while one result waits on m_tready.
// Reset: synchronous, active high; the parser expects magic byte zero, the CRC is all
// ones, the output stage is empty and record_magic is zero.
module log_record_deframer_crc32 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [lrd_pkg::TDATA_W-1:0] m_tdata,
  // [2:0] event_kind, [10:3] payload_byte, [44:11] payload_index,
  // [108:45] sequence_number, [116:109] operation_code, [148:117] document_id,
  // [180:149] vector_length, [212:181] metadata_length, [244:213] stored_check,
  // [276:245] computed_check, rest zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data   // record_magic
);

  typedef enum logic [3:0] {
    PH_MAGIC = 4'd0,
    PH_SEQ   = 4'd1,
    PH_OP    = 4'd2,
    PH_ID    = 4'd3,
    PH_DIM   = 4'd4,
    PH_VEC   = 4'd5,
    PH_MLEN  = 4'd6,
    PH_META  = 4'd7,
    PH_CHECK = 4'd8,
    PH_WAIT  = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    EV_VECTOR    = 3'd0,
    EV_META      = 3'd1,
    EV_GOOD      = 3'd2,
    EV_BAD_CRC   = 3'd3,
    EV_BAD_MAGIC = 3'd4,
    EV_TRUNC     = 3'd5
  } kind_t;

  logic [31:0] record_magic;

  phase_t      phase, phase_next;
  logic [33:0] cnt, cnt_next, cnt_inc, field_size;
  logic [63:0] seq, seq_next;
  logic [7:0]  op, op_next;
  logic [31:0] id, id_next;
  logic [31:0] dim, dim_next;
  logic [31:0] mlen, mlen_next;
  logic [31:0] chk, chk_next;
  logic [31:0] crc, crc_next;

  logic             accept;
  logic             buf_ready;
  logic             res_valid;
  lrd_pkg::result_t res;
  lrd_pkg::result_t out_data;
  logic             fdone;
  logic             rec_done;
  logic             clear_rec;
  logic             wait_after;
  logic [7:0]       magic_byte;
  logic [31:0]      calc;

  assign cfg_ready = 1'b1;
  assign s_tready  = buf_ready;
  assign accept    = s_tvalid && s_tready;
  assign m_tdata   = {{(lrd_pkg::TDATA_W - lrd_pkg::RESULT_W){1'b0}}, out_data};

  assign magic_byte = record_magic[cnt[1:0]*8 +: 8];
  assign cnt_inc    = cnt + 34'd1;
  assign fdone      = (cnt_inc >= field_size);
  assign calc       = ~crc;

  // Hold the expected magic
  always_ff @(posedge clk) begin
    if (rst) begin
      record_magic <= '0;
    end else if (cfg_valid && cfg_ready) begin
      record_magic <= cfg_data;
    end
  end

  // Select the size of the current field or part
  always_comb begin
    case (phase)
      PH_MAGIC: field_size = 34'd4;
      PH_SEQ:   field_size = 34'd8;
      PH_OP:    field_size = 34'd1;
      PH_VEC:   field_size = {dim, 2'b00};
      PH_META:  field_size = {2'b00, mlen};
      default:  field_size = 34'd4;
    endcase
  end

  // Parse one byte
  always_comb begin
    phase_next = phase;
    cnt_next   = cnt;
    seq_next   = seq;
    op_next    = op;
    id_next    = id;
    dim_next   = dim;
    mlen_next  = mlen;
    chk_next   = chk;
    crc_next   = crc;
    res        = '0;
    res_valid  = 1'b0;
    rec_done   = 1'b0;
    clear_rec  = 1'b0;
    wait_after = 1'b0;

    if (phase == PH_MAGIC && s_tdata != magic_byte) begin
      // Bad magic: report at once, then ignore bytes up to the end flag
      res.event_kind = EV_BAD_MAGIC;
      res_valid      = 1'b1;
      clear_rec      = 1'b1;
      wait_after     = !s_tlast;
    end else if (phase <= PH_CHECK) begin
      if (phase != PH_CHECK) begin
        crc_next = lrd_pkg::crc32_byte(crc, s_tdata);
      end
      cnt_next = fdone ? 34'd0 : cnt_inc;

      case (phase)
        PH_MAGIC: begin
          if (fdone) phase_next = PH_SEQ;
        end
        PH_SEQ: begin
          seq_next[cnt[2:0]*8 +: 8] = seq[cnt[2:0]*8 +: 8] | s_tdata;
          if (fdone) phase_next = PH_OP;
        end
        PH_OP: begin
          op_next = s_tdata;
          if (fdone) phase_next = PH_ID;
        end
        PH_ID: begin
          id_next[cnt[1:0]*8 +: 8] = id[cnt[1:0]*8 +: 8] | s_tdata;
          if (fdone) phase_next = PH_DIM;
        end
        PH_DIM: begin
          dim_next[cnt[1:0]*8 +: 8] = dim[cnt[1:0]*8 +: 8] | s_tdata;
          if (fdone) phase_next = (dim_next != '0) ? PH_VEC : PH_MLEN;
        end
        PH_VEC: begin
          res.event_kind    = EV_VECTOR;
          res.payload_byte  = s_tdata;
          res.payload_index = cnt;
          res_valid         = 1'b1;
          if (fdone) phase_next = PH_MLEN;
        end
        PH_MLEN: begin
          mlen_next[cnt[1:0]*8 +: 8] = mlen[cnt[1:0]*8 +: 8] | s_tdata;
          if (fdone) phase_next = (mlen_next != '0) ? PH_META : PH_CHECK;
        end
        PH_META: begin
          res.event_kind    = EV_META;
          res.payload_byte  = s_tdata;
          res.payload_index = cnt;
          res_valid         = 1'b1;
          if (fdone) phase_next = PH_CHECK;
        end
        default: begin
          chk_next[cnt[1:0]*8 +: 8] = chk[cnt[1:0]*8 +: 8] | s_tdata;
          if (fdone) begin
            res.event_kind      = (calc == chk_next) ? EV_GOOD : EV_BAD_CRC;
            res.sequence_number = seq;
            res.operation_code  = op;
            res.document_id     = id;
            res.vector_length   = dim;
            res.metadata_length = mlen;
            res.stored_check    = chk_next;
            res.computed_check  = calc;
            res_valid           = 1'b1;
            rec_done            = 1'b1;
            clear_rec           = 1'b1;
          end
        end
      endcase

      // End flag inside a record: replace any result with truncation
      if (s_tlast && !rec_done) begin
        res            = '0;
        res.event_kind = EV_TRUNC;
        res_valid      = 1'b1;
        clear_rec      = 1'b1;
      end
    end else begin
      // Waiting after a stop: the end flag rearms parsing
      clear_rec  = s_tlast;
      wait_after = !s_tlast;
    end

    if (clear_rec) begin
      phase_next = PH_MAGIC;
      cnt_next   = '0;
      seq_next   = '0;
      op_next    = '0;
      id_next    = '0;
      dim_next   = '0;
      mlen_next  = '0;
      chk_next   = '0;
      crc_next   = lrd_pkg::CRC_INIT;
    end
    if (wait_after) begin
      phase_next = PH_WAIT;
    end
  end

  // Advance parser state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_MAGIC;
      cnt   <= '0;
      seq   <= '0;
      op    <= '0;
      id    <= '0;
      dim   <= '0;
      mlen  <= '0;
      chk   <= '0;
      crc   <= lrd_pkg::CRC_INIT;
    end else if (accept) begin
      phase <= phase_next;
      cnt   <= cnt_next;
      seq   <= seq_next;
      op    <= op_next;
      id    <= id_next;
      dim   <= dim_next;
      mlen  <= mlen_next;
      chk   <= chk_next;
      crc   <= crc_next;
    end
  end

  lrd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_data (res),
    .ready     (buf_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_data    (out_data)
  );

`ifndef NO_ASSERTIONS
  // A full skid stage implies the output register holds a result
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("skid stage full while output register empty");

  // An accepted end flag always leaves the parser expecting a new record
  a_end_rearms: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> (phase == PH_MAGIC && cnt == '0))
    else $error("parser not rearmed after end of stream");

  // At the start of a record the CRC is at its initial value
  a_crc_fresh: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_MAGIC && cnt == '0) |-> (crc == lrd_pkg::CRC_INIT))
    else $error("CRC not reset at record start");
`endif

endmodule
